@@ sv/tmp_pkg.sv @@
package tmp_pkg;

   localparam int PHASE_W = 3;

   typedef enum logic [PHASE_W-1:0] {
      PH_DONE   = 3'd0,
      PH_IDLE   = 3'd1,
      PH_LINEAR = 3'd2,
      PH_ACCEL  = 3'd3,
      PH_CRUISE = 3'd4,
      PH_DECEL  = 3'd5
   } phase_type;

endpackage

@@ sv/trapezoid_motion_profile.sv @@
// Trapezoidal velocity profile sampler. Each transfer on the req_ side carries
// elapsed time, segment length and ramp-up and ramp-down times (unsigned
// Q(INT_BITS).(FRAC_BITS) seconds); one result comes back per item with the
// path fraction (Q1.FRAC_BITS), the normalized speed (saturating) and a phase
// code. The block takes one item per clock while req_full is low and returns
// results in order. Results reach the rsp_ ports through two bit-per-stage
// pipelined dividers: one for the peak speed over the front half and one for
// the speed and path products over the back half, joined by a two-entry
// queue. The block keeps no state between items.
module trapezoid_motion_profile
   import tmp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_elapsed_time,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_segment_duration,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_ramp_up_time,
   input  logic [INT_BITS+FRAC_BITS-1:0] req_ramp_down_time,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [FRAC_BITS:0]            rsp_path_fraction,
   output logic [INT_BITS+FRAC_BITS-1:0] rsp_norm_speed,
   output logic [PHASE_W-1:0]            rsp_phase
);

   localparam int W      = INT_BITS + FRAC_BITS;
   localparam int NUM1_W = 2 * FRAC_BITS + 2;
   localparam int MID_W  = PHASE_W + 2 * (W + 1) + W + NUM1_W;
   localparam int OUT_W  = FRAC_BITS + 1 + W + PHASE_W;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic             mid_push, mid_full, mid_pop, mid_empty;
   logic [MID_W-1:0] mid_wr, mid_rd;
   logic             out_push, out_full;
   logic [OUT_W-1:0] out_wr, out_rd;

   tmp_front #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS),
      .MID_W     (MID_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (req_push),
      .full             (req_full),
      .elapsed_time     (req_elapsed_time),
      .segment_duration (req_segment_duration),
      .ramp_up_time     (req_ramp_up_time),
      .ramp_down_time   (req_ramp_down_time),
      .mid_full         (mid_full),
      .mid_push         (mid_push),
      .mid_data         (mid_wr)
   );

   tmp_fifo #(
      .WIDTH (MID_W),
      .DEPTH (2)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   tmp_back #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS),
      .MID_W     (MID_W),
      .OUT_W     (OUT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wr)
   );

   tmp_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (2)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .empty   (rsp_empty)
   );

   assign {rsp_path_fraction, rsp_norm_speed, rsp_phase} = out_rd;

   a_path_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_path_fraction <= ONE)
      else $error("path fraction above one");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_phase == PH_DONE) |->
         (rsp_path_fraction == ONE && rsp_norm_speed == '0))
      else $error("done result not at end of path");

   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_phase == PH_IDLE) |->
         (rsp_path_fraction == '0 && rsp_norm_speed == '0))
      else $error("not-started result moving");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full queue");

endmodule

@@ sv/tmp_fifo.sv @@
module tmp_fifo
   import tmp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   // depth is a power of two so the pointers wrap on their own
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/tmp_div.sv @@
module tmp_div
   import tmp_pkg::*;
#(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 25,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // one quotient bit per stage, restoring; the numerator register collects
   // quotient bits from the bottom as its top bits shift into the remainder
   logic [NUM_W-1:0]  valid_ff, valid_in;
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  num_in  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_in  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [DEN_W-1:0]  den_in  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic [SIDE_W-1:0] side_in [NUM_W];

   always_comb begin
      logic [NUM_W-1:0]  pn;
      logic [DEN_W-1:0]  pr;
      logic [DEN_W-1:0]  pd;
      logic [SIDE_W-1:0] ps;
      logic              pv;
      logic [DEN_W:0]    shifted;
      logic [DEN_W:0]    diff;
      for (int i = 0; i < NUM_W; i++) begin
         if (i == 0) begin
            pn = in_num;
            pr = '0;
            pd = in_den;
            ps = in_side;
            pv = in_valid;
         end else begin
            pn = num_ff[i-1];
            pr = rem_ff[i-1];
            pd = den_ff[i-1];
            ps = side_ff[i-1];
            pv = valid_ff[i-1];
         end
         shifted = {pr, pn[NUM_W-1]};
         diff    = shifted - {1'b0, pd};
         if (shifted >= {1'b0, pd}) begin
            rem_in[i] = diff[DEN_W-1:0];
            num_in[i] = {pn[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = shifted[DEN_W-1:0];
            num_in[i] = {pn[NUM_W-2:0], 1'b0};
         end
         den_in[i]   = pd;
         side_in[i]  = ps;
         valid_in[i] = pv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            num_ff[i]  <= num_in[i];
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

@@ sv/tmp_front.sv @@
module tmp_front
   import tmp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8,
   parameter int MID_W     = 113
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [INT_BITS+FRAC_BITS-1:0] elapsed_time,
   input  logic [INT_BITS+FRAC_BITS-1:0] segment_duration,
   input  logic [INT_BITS+FRAC_BITS-1:0] ramp_up_time,
   input  logic [INT_BITS+FRAC_BITS-1:0] ramp_down_time,
   input  logic                         mid_full,
   output logic                         mid_push,
   output logic [MID_W-1:0]             mid_data
);

   localparam int W      = INT_BITS + FRAC_BITS;
   localparam int NUM1_W = 2 * FRAC_BITS + 2;
   localparam int SIDE_W = PHASE_W + 2 * (W + 1) + W;
   localparam logic [NUM1_W-1:0] ONE_SQ     = NUM1_W'(1) << (2 * FRAC_BITS);
   localparam logic [NUM1_W-1:0] TWO_ONE_SQ = NUM1_W'(1) << (2 * FRAC_BITS + 1);
   localparam logic [W:0]        TWO_ONE    = (W + 1)'(1) << (FRAC_BITS + 1);

   logic            en;
   logic            accept;
   logic [W:0]      two_t, sum_ad, t_plus_d, d2;
   logic [W-1:0]    u;
   phase_type       phase_in;
   logic [NUM1_W-1:0] num1_in;
   logic [W:0]      den1_in, x2_in, z_in;
   logic [W-1:0]    m_in;

   logic            f0_valid_ff;
   phase_type       f0_phase_ff;
   logic [NUM1_W-1:0] f0_num1_ff;
   logic [W:0]      f0_den1_ff, f0_x2_ff, f0_z_ff;
   logic [W-1:0]    f0_m_ff;

   logic              div_valid;
   logic [NUM1_W-1:0] div_quo;
   logic [SIDE_W-1:0] div_side;

   // the whole divider pipeline holds while its finished item cannot leave
   assign en       = !div_valid || !mid_full;
   assign full     = !en;
   assign accept   = push && en;
   assign mid_push = div_valid && !mid_full;
   assign mid_data = {div_side, div_quo};

   always_comb begin
      two_t    = {segment_duration, 1'b0};
      sum_ad   = {1'b0, ramp_up_time} + {1'b0, ramp_down_time};
      t_plus_d = {1'b0, elapsed_time} + {1'b0, ramp_down_time};
      d2       = two_t - sum_ad;
      u        = segment_duration - elapsed_time;

      priority if (segment_duration == '0) begin
         phase_in = PH_DONE;
      end else if (elapsed_time == '0) begin
         phase_in = PH_IDLE;
      end else if (elapsed_time >= segment_duration) begin
         phase_in = PH_DONE;
      end else if ((ramp_up_time == '0 && ramp_down_time == '0) || two_t <= sum_ad) begin
         phase_in = PH_LINEAR;
      end else if (elapsed_time < ramp_up_time) begin
         phase_in = PH_ACCEL;
      end else if (t_plus_d < {1'b0, segment_duration}) begin
         phase_in = PH_CRUISE;
      end else begin
         phase_in = PH_DECEL;
      end

      num1_in = TWO_ONE_SQ;
      den1_in = d2;
      x2_in   = '0;
      z_in    = TWO_ONE;
      m_in    = elapsed_time;
      unique case (phase_in)
         PH_LINEAR: begin
            num1_in = ONE_SQ;
            den1_in = {1'b0, segment_duration};
            x2_in   = {1'b0, elapsed_time};
            z_in    = {1'b0, segment_duration};
         end
         PH_ACCEL: begin
            x2_in = {1'b0, elapsed_time};
            z_in  = {1'b0, ramp_up_time};
         end
         PH_CRUISE: begin
            x2_in = {elapsed_time, 1'b0} - {1'b0, ramp_up_time};
         end
         PH_DECEL: begin
            x2_in = {1'b0, u};
            z_in  = {1'b0, ramp_down_time};
            m_in  = u;
         end
         default: begin
            den1_in = {1'b0, segment_duration};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else if (en) begin
         f0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_phase_ff <= phase_in;
         f0_num1_ff  <= num1_in;
         f0_den1_ff  <= den1_in;
         f0_x2_ff    <= x2_in;
         f0_z_ff     <= z_in;
         f0_m_ff     <= m_in;
      end
   end

   tmp_div #(
      .NUM_W  (NUM1_W),
      .DEN_W  (W + 1),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f0_valid_ff),
      .in_num    (f0_num1_ff),
      .in_den    (f0_den1_ff),
      .in_side   ({f0_phase_ff, f0_x2_ff, f0_z_ff, f0_m_ff}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

endmodule

@@ sv/tmp_back.sv @@
module tmp_back
   import tmp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 8,
   parameter int MID_W     = 113,
   parameter int OUT_W     = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   input  logic [MID_W-1:0] mid_data,
   output logic             mid_pop,
   input  logic             out_full,
   output logic             out_push,
   output logic [OUT_W-1:0] out_data
);

   localparam int W      = INT_BITS + FRAC_BITS;
   localparam int NUM1_W = 2 * FRAC_BITS + 2;
   localparam int PW     = NUM1_W + W + 1;
   localparam int SIDE_W = PHASE_W + NUM1_W + W;
   localparam int P2_W   = NUM1_W + W;
   localparam logic [NUM1_W-1:0] ONE_N  = NUM1_W'(1) << FRAC_BITS;
   localparam logic [PW-1:0]     ONE_P  = PW'(1) << FRAC_BITS;
   localparam logic [PW-1:0]     VMAX_P = (PW'(1) << W) - PW'(1);

   logic en;

   // unpacked queue entry
   logic [NUM1_W-1:0] mid_q1;
   logic [W:0]        mid_x2, mid_z;
   logic [W-1:0]      mid_m;
   logic [PHASE_W-1:0] mid_phase;

   logic              b0_valid_ff;
   phase_type         b0_phase_ff;
   logic [NUM1_W-1:0] b0_q1_ff;
   logic [W:0]        b0_x2_ff, b0_z_ff;
   logic [W-1:0]      b0_m_ff;

   logic [NUM1_W-1:0] mul_a;
   logic [PW-1:0]     prod_in;
   logic              b1_valid_ff;
   logic [PW-1:0]     b1_prod_ff;
   logic [W:0]        b1_z_ff;
   logic [SIDE_W-1:0] b1_side_ff;

   logic              div_valid;
   logic [PW-1:0]     div_quo;
   logic [SIDE_W-1:0] div_side;
   logic [P2_W-1:0]   prod2_in;

   logic              b3_valid_ff;
   phase_type         b3_phase_ff;
   logic [NUM1_W-1:0] b3_q1_ff;
   logic [PW-1:0]     b3_q2_ff;
   logic [P2_W-1:0]   b3_prod2_ff;

   logic [PW-1:0]        tail;
   logic [PW-1:0]        s_wide, v_wide;
   logic [FRAC_BITS:0]   path;
   logic [W-1:0]         speed;

   assign {mid_phase, mid_x2, mid_z, mid_m, mid_q1} = mid_data;

   assign en       = !b3_valid_ff || !out_full;
   assign mid_pop  = en && !mid_empty;
   assign out_push = b3_valid_ff && !out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (en) begin
         b0_valid_ff <= !mid_empty;
         b1_valid_ff <= b0_valid_ff;
         b3_valid_ff <= div_valid;
      end
   end

   // linear: t * ONE / T, otherwise vmax times the phase's time operand
   assign mul_a   = (b0_phase_ff == PH_LINEAR) ? ONE_N : b0_q1_ff;
   assign prod_in = PW'(mul_a) * PW'(b0_x2_ff);

   assign prod2_in = P2_W'(div_quo[NUM1_W-1:0]) * P2_W'(div_side[W-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         b0_phase_ff <= phase_type'(mid_phase);
         b0_q1_ff    <= mid_q1;
         b0_x2_ff    <= mid_x2;
         b0_z_ff     <= mid_z;
         b0_m_ff     <= mid_m;
         b1_prod_ff  <= prod_in;
         b1_z_ff     <= b0_z_ff;
         b1_side_ff  <= {b0_phase_ff, b0_q1_ff, b0_m_ff};
         b3_phase_ff <= phase_type'(div_side[SIDE_W-1 -: PHASE_W]);
         b3_q1_ff    <= div_side[W +: NUM1_W];
         b3_q2_ff    <= div_quo;
         b3_prod2_ff <= prod2_in;
      end
   end

   tmp_div #(
      .NUM_W  (PW),
      .DEN_W  (W + 1),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b1_valid_ff),
      .in_num    (b1_prod_ff),
      .in_den    (b1_z_ff),
      .in_side   (b1_side_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   always_comb begin
      tail = PW'(b3_prod2_ff >> (FRAC_BITS + 1));
      unique case (b3_phase_ff)
         PH_DONE: begin
            s_wide = ONE_P;
            v_wide = '0;
         end
         PH_IDLE: begin
            s_wide = '0;
            v_wide = '0;
         end
         PH_LINEAR, PH_CRUISE: begin
            s_wide = b3_q2_ff;
            v_wide = PW'(b3_q1_ff);
         end
         PH_ACCEL: begin
            s_wide = tail;
            v_wide = b3_q2_ff;
         end
         PH_DECEL: begin
            s_wide = (tail >= ONE_P) ? '0 : ONE_P - tail;
            v_wide = b3_q2_ff;
         end
         default: begin
            s_wide = '0;
            v_wide = '0;
         end
      endcase
      path  = (s_wide > ONE_P) ? ONE_P[FRAC_BITS:0] : s_wide[FRAC_BITS:0];
      speed = (v_wide > VMAX_P) ? VMAX_P[W-1:0] : v_wide[W-1:0];
   end

   assign out_data = {path, speed, PHASE_W'(b3_phase_ff)};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tmp_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = 8;
   localparam int TW        = INT_BITS + FRAC_BITS;
   localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
   localparam longint unsigned SPEED_MAX = (64'd1 << TW) - 1;
   localparam longint unsigned MX = 64'hFF_FFFF;
   localparam int LATENCY    = 5 * FRAC_BITS + INT_BITS + 11;
   localparam int N_RANDOM   = 1900;
   localparam int STALL_LONG = 400;

   typedef struct packed {
      logic [TW-1:0] elapsed;
      logic [TW-1:0] duration;
      logic [TW-1:0] ramp_up;
      logic [TW-1:0] ramp_down;
   } sample_t;

   typedef struct packed {
      logic [FRAC_BITS:0] path;
      logic [TW-1:0]      speed;
      phase_type          phase;
   } profile_t;

   typedef struct {
      sample_t  smp;
      logic     known;
      profile_t res;
   } row_t;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [TW-1:0]       req_elapsed_time;
   logic [TW-1:0]       req_segment_duration;
   logic [TW-1:0]       req_ramp_up_time;
   logic [TW-1:0]       req_ramp_down_time;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [FRAC_BITS:0]  rsp_path_fraction;
   logic [TW-1:0]       rsp_norm_speed;
   logic [PHASE_W-1:0]  rsp_phase;

   profile_t expected_profiles[$];
   int       mismatches;
   bit       hold_off;

   trapezoid_motion_profile #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) dut (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // floor(x*y/z) with a wide product, saturated to 64 bits
   function automatic longint unsigned scale_div(longint unsigned x, longint unsigned y,
                                                 longint unsigned z);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = 128'(x) * 128'(y);
      quo  = prod / 128'(z);
      if (quo[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return quo[63:0];
   endfunction

   function automatic profile_t pack_profile(longint unsigned s, longint unsigned v,
                                             phase_type ph);
      profile_t r;
      if (s > ONE) s = ONE;
      if (v > SPEED_MAX) v = SPEED_MAX;
      r.path  = s[FRAC_BITS:0];
      r.speed = v[TW-1:0];
      r.phase = ph;
      return r;
   endfunction

   function automatic profile_t predict_profile(sample_t smp);
      longint unsigned t, tt, a, d, span, vmax, v, u, tail;
      t  = smp.elapsed;
      tt = smp.duration;
      a  = smp.ramp_up;
      d  = smp.ramp_down;
      if (tt == 0) return pack_profile(ONE, 0, PH_DONE);
      if (t == 0) return pack_profile(0, 0, PH_IDLE);
      if (t >= tt) return pack_profile(ONE, 0, PH_DONE);
      if ((a == 0 && d == 0) || 2 * tt <= a + d)
         return pack_profile(scale_div(t, ONE, tt), scale_div(ONE, ONE, tt), PH_LINEAR);
      span = 2 * tt - a - d;
      vmax = scale_div(2 * ONE, ONE, span);
      if (t < a) begin
         v = scale_div(vmax, t, a);
         return pack_profile(scale_div(v, t, 2 * ONE), v, PH_ACCEL);
      end
      if (t + d < tt)
         return pack_profile(scale_div(vmax, 2 * t - a, 2 * ONE), vmax, PH_CRUISE);
      u    = tt - t;
      v    = scale_div(vmax, u, d);
      tail = scale_div(v, u, 2 * ONE);
      return pack_profile((tail >= ONE) ? 0 : ONE - tail, v, PH_DECEL);
   endfunction

   function automatic row_t mk_row(longint unsigned t, longint unsigned tt,
                                   longint unsigned a, longint unsigned d, logic known,
                                   longint unsigned s, longint unsigned v, phase_type ph);
      row_t r;
      r.smp   = '{t[TW-1:0], tt[TW-1:0], a[TW-1:0], d[TW-1:0]};
      r.known = known;
      r.res   = pack_profile(s, v, ph);
      return r;
   endfunction

   function automatic sample_t random_sample();
      sample_t     smp;
      int          kind;
      int unsigned tt;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         smp = {$urandom(), $urandom(), $urandom()};
      end else begin
         tt = (kind < 4) ? $urandom_range(1, 16'hFFFF) : $urandom_range(1, 24'hFF_FFFF);
         smp.duration = TW'(tt);
         smp.elapsed  = (kind == 9) ? TW'($urandom_range(0, 24'hFF_FFFF))
                                    : TW'($urandom_range(0, tt));
         smp.ramp_up   = ($urandom_range(0, 7) == 0) ? '0 : TW'($urandom_range(0, tt));
         smp.ramp_down = ($urandom_range(0, 7) == 0) ? '0 : TW'($urandom_range(0, tt));
         if (kind == 8) begin
            smp.ramp_up   = TW'($urandom_range(0, tt / 8));
            smp.ramp_down = TW'($urandom_range(0, tt / 8));
         end
      end
      return smp;
   endfunction

   // push stays high from one transfer to the next when there is no gap
   task automatic send_sample(sample_t smp, logic known, profile_t res);
      int gap;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push             <= 1'b1;
      req_elapsed_time     <= smp.elapsed;
      req_segment_duration <= smp.duration;
      req_ramp_up_time     <= smp.ramp_up;
      req_ramp_down_time   <= smp.ramp_down;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_profiles.push_back(known ? res : predict_profile(smp));
   endtask

   // result side
   initial begin
      int       wait_cycles;
      profile_t exp_res;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (wait_cycles != 0 || hold_off) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (expected_profiles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer on result side");
         end else begin
            exp_res = expected_profiles.pop_front();
            if (rsp_path_fraction !== exp_res.path || rsp_norm_speed !== exp_res.speed ||
                rsp_phase !== exp_res.phase) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp path=%0d speed=%0d phase=%0d got %0d %0d %0d",
                           exp_res.path, exp_res.speed, exp_res.phase,
                           rsp_path_fraction, rsp_norm_speed, rsp_phase);
            end
         end
      end
   end

   // long receiver stall, counted on its own
   initial begin
      hold_off = 1'b0;
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off = 1'b1;
      repeat (STALL_LONG) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #20ms;
      $display("[trapezoid_motion_profile] ERROR");
      $finish;
   end

   initial begin
      row_t     rows[$];
      profile_t dummy;
      dummy                = '0;
      mismatches           = 0;
      reset                = 1'b1;
      req_push             = 1'b0;
      req_elapsed_time     = '0;
      req_segment_duration = '0;
      req_ramp_up_time     = '0;
      req_ramp_down_time   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(mk_row(0, 0, 0, 0, 1, ONE, 0, PH_DONE));
      rows.push_back(mk_row(MX, 0, MX, MX, 1, ONE, 0, PH_DONE));
      rows.push_back(mk_row(0, MX, 0, 0, 1, 0, 0, PH_IDLE));
      rows.push_back(mk_row(MX, MX, 0, 0, 1, ONE, 0, PH_DONE));
      rows.push_back(mk_row(5, 3, 1, 1, 1, ONE, 0, PH_DONE));
      rows.push_back(mk_row(ONE / 2, ONE, 0, 0, 1, ONE / 2, ONE, PH_LINEAR));
      rows.push_back(mk_row(1, 1, 0, 0, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(1, 2, 0, 0, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(MX - 1, MX, 0, 0, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(100, 1000, 1000, 1000, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(100, 1000, MX, MX, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(100, 1000, 400, 300, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(500, 1000, 400, 300, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(900, 1000, 400, 300, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(500, 1000, 700, 700, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(650, 1000, 700, 700, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(1, MX, 1, 0, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(1, 2, 1, 1, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(1, 3, 2, 2, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(1, 3, 0, 2, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(MX - 1, MX, MX - 1, 1, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(MX / 2, MX, 0, MX - 1, 0, 0, 0, PH_DONE));
      rows.push_back(mk_row(123, 4000, 3999, 3999, 0, 0, 0, PH_DONE));
      foreach (rows[i]) send_sample(rows[i].smp, rows[i].known, rows[i].res);

      for (int n = 0; n < N_RANDOM; n++) begin
         // sender pause until the block has drained
         if (n == 1200) begin
            req_push <= 1'b0;
            while (expected_profiles.size() != 0) @(posedge clock);
         end
         send_sample(random_sample(), 1'b0, dummy);
      end
      req_push <= 1'b0;

      while (expected_profiles.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_profiles.size() == 0) begin
         $display("[trapezoid_motion_profile] OK");
      end else begin
         $display("[trapezoid_motion_profile] ERROR");
      end
      $finish;
   end

endmodule
